### sv/doss_pkg.sv
// Shared types and constants for the disk offset to skewed sector translator.
// Used by the divider pipeline, the skew table, the top level and the checker.
package doss_pkg;

  // Field widths of the beats
  localparam int REMAIN_W    = 16;
  localparam int TRACK_W     = 17;
  localparam int SECTOR_W    = 8;
  localparam int INSEC_W     = 10;
  localparam int CHUNK_W     = 11;
  localparam int M_TDATA_W   = 48;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int SPT_W       = 7;
  localparam int SLOG_W      = 4;
  localparam int SKEW_W      = 6;
  localparam int AREA_W      = 24;

  localparam logic [CFG_ADDR_W-1:0] REG_SECTORS  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_SIZE_LOG = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_SKEW     = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_FIRST_ID = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] REG_AREA     = CFG_ADDR_W'(4);

  // Register values after reset
  localparam logic [SPT_W-1:0]    RST_SECTORS  = SPT_W'(26);
  localparam logic [SLOG_W-1:0]   RST_SIZE_LOG = SLOG_W'(7);
  localparam logic [SKEW_W-1:0]   RST_SKEW     = SKEW_W'(0);
  localparam logic [SECTOR_W-1:0] RST_FIRST_ID = SECTOR_W'(1);
  localparam logic [AREA_W-1:0]   RST_AREA     = AREA_W'(0);

  // Legal sector size range, as log2 of bytes
  localparam logic [SLOG_W-1:0] SIZE_LOG_MIN = SLOG_W'(7);
  localparam logic [SLOG_W-1:0] SIZE_LOG_MAX = SLOG_W'(10);

  // Quotient bits resolved per divider stage
  localparam int DIV_BITS_PER_STAGE = 4;

  // Per-item fields that ride along the divider
  typedef struct packed {
    logic                 beyond_end;
    logic [INSEC_W-1:0]   byte_in_sector;
    logic [CHUNK_W-1:0]   chunk_length;
  } doss_side_t;

  // Skew table build sequencer
  typedef enum logic [1:0] {
    BLD_START,
    BLD_REDUCE,
    BLD_FILL,
    BLD_IDLE
  } doss_build_t;

endpackage

### sv/doss_div.sv
// Pipelined restoring divider: sector number by sectors per track.
// Resolves DIV_BITS_PER_STAGE quotient bits per stage; depends on doss_pkg.
module doss_div import doss_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int MAX_SECTORS = 64,
  localparam int NW  = $clog2(MAX_SECTORS + 1),
  localparam int QW  = OFFSET_BITS - 7,
  localparam int NST = (QW + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE,
  localparam int PW  = NST * DIV_BITS_PER_STAGE
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [QW-1:0]      in_dividend,
  input  doss_side_t         in_side,
  input  logic [NW-1:0]      n_eff,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TRACK_W-1:0] out_quot,
  output logic [NW-1:0]      out_rem,
  output doss_side_t         out_side
);

  logic          st_vld  [NST];
  logic [NW-1:0] st_rem  [NST];
  logic [PW-1:0] st_work [NST];
  doss_side_t    st_side [NST];
  logic          st_rdy  [NST+1];

  assign st_rdy[NST] = out_ready;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic          src_vld;
    logic [NW-1:0] src_rem;
    logic [PW-1:0] src_work;
    doss_side_t    src_side;
    logic [NW-1:0] nx_rem;
    logic [PW-1:0] nx_work;
    logic [NW:0]   part;

    // Stage source: the input port or the previous stage
    if (s == 0) begin : g_first
      assign src_vld  = in_valid;
      assign src_rem  = '0;
      assign src_work = PW'(in_dividend);
      assign src_side = in_side;
    end else begin : g_later
      assign src_vld  = st_vld[s-1];
      assign src_rem  = st_rem[s-1];
      assign src_work = st_work[s-1];
      assign src_side = st_side[s-1];
    end

    // Shift-subtract steps; dividend bits leave the top, quotient bits enter the bottom
    always_comb begin
      nx_rem  = src_rem;
      nx_work = src_work;
      part    = '0;
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        part    = {nx_rem, nx_work[PW-1]};
        nx_work = {nx_work[PW-2:0], 1'b0};
        if (part >= {1'b0, n_eff}) begin
          part       = part - {1'b0, n_eff};
          nx_work[0] = 1'b1;
        end
        nx_rem = part[NW-1:0];
      end
    end

    // Stage moves when empty or when the next one moves
    assign st_rdy[s] = !st_vld[s] || st_rdy[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[s] <= 1'b0;
      end else if (st_rdy[s]) begin
        st_vld[s] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (st_rdy[s]) begin
        st_rem[s]  <= nx_rem;
        st_work[s] <= nx_work;
        st_side[s] <= src_side;
      end
    end
  end

  assign in_ready  = st_rdy[0];
  assign out_valid = st_vld[NST-1];
  assign out_quot  = TRACK_W'(st_work[NST-1]);
  assign out_rem   = st_rem[NST-1];
  assign out_side  = st_side[NST-1];

endmodule

### sv/doss_table.sv
// Skew table: build sequencer and table memory with a registered read port.
// Step-and-skip-occupied fill, or identity when the step is zero; uses doss_pkg.
module doss_table import doss_pkg::*; #(
  parameter int MAX_SECTORS = 64,
  localparam int NW = $clog2(MAX_SECTORS + 1),
  localparam int IW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rebuild,
  input  logic [NW-1:0]     n_eff,
  input  logic [SKEW_W-1:0] skew_step,
  output logic              busy,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_addr,
  output logic [IW-1:0]     rd_data
);

  localparam int AW = ((NW > SKEW_W) ? NW : SKEW_W) + 1;

  doss_build_t            state, state_next;
  logic [NW-1:0]          idx, idx_next;
  logic [IW-1:0]          pos, pos_next;
  logic [SKEW_W-1:0]      stepr, stepr_next;
  logic [MAX_SECTORS-1:0] taken;
  logic                   taken_set;
  logic                   we;
  logic [IW-1:0]          wdata;
  logic [IW-1:0]          mem [MAX_SECTORS];

  logic [AW-1:0] n_ext, pos_inc, pos_hop;
  logic          fill_done;

  assign n_ext     = AW'(n_eff);
  assign pos_inc   = AW'(pos) + AW'(1);
  assign pos_hop   = AW'(pos) + AW'(stepr);
  assign fill_done = (idx == n_eff);
  assign busy      = (state != BLD_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BLD_START:  state_next = BLD_REDUCE;
      BLD_REDUCE: if (AW'(stepr) < n_ext) state_next = BLD_FILL;
      BLD_FILL:   if (fill_done) state_next = BLD_IDLE;
      BLD_IDLE:   state_next = BLD_IDLE;
      default:    state_next = BLD_START;
    endcase
    if (rebuild) state_next = BLD_START;
  end

  // Sequencer datapath and table writes
  always_comb begin
    idx_next   = idx;
    pos_next   = pos;
    stepr_next = stepr;
    taken_set  = 1'b0;
    we         = 1'b0;
    wdata      = pos;
    unique case (state)
      BLD_START: begin
        idx_next   = '0;
        pos_next   = '0;
        stepr_next = skew_step;
      end
      BLD_REDUCE: begin
        // step modulo sector count, one subtraction a cycle
        if (AW'(stepr) >= n_ext) stepr_next = SKEW_W'(AW'(stepr) - n_ext);
      end
      BLD_FILL: begin
        if (!fill_done) begin
          if (skew_step == '0) begin
            we       = 1'b1;
            wdata    = IW'(idx);
            idx_next = idx + NW'(1);
          end else if (taken[pos]) begin
            pos_next = (pos_inc == n_ext) ? '0 : IW'(pos_inc);
          end else begin
            we        = 1'b1;
            wdata     = pos;
            taken_set = 1'b1;
            idx_next  = idx + NW'(1);
            pos_next  = (pos_hop >= n_ext) ? IW'(pos_hop - n_ext) : IW'(pos_hop);
          end
        end
      end
      BLD_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BLD_START;
      idx   <= '0;
      pos   <= '0;
      stepr <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pos   <= pos_next;
      stepr <= stepr_next;
    end
  end

  // Occupied places of the current build
  always_ff @(posedge clk) begin
    if (rst || state == BLD_START) begin
      taken <= '0;
    end else if (taken_set) begin
      taken[pos] <= 1'b1;
    end
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (we) mem[idx[IW-1:0]] <= wdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

### sv/disk_offset_to_skewed_sector.sv
// Disk offset to skewed sector translator, top level.
// Registered path: front stage, divider pipeline (4 quotient bits a stage), table, output.
// Throughput: one beat per cycle unless back-pressure or a table build stalls the input.
// Reset is synchronous; it and any write of sectors_per_track or skew_step start a
// table build that holds s_tready low until the table is complete.
// Instantiates doss_div and doss_table; uses doss_pkg.
module disk_offset_to_skewed_sector import doss_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int MAX_SECTORS = 64,
  localparam int S_TDATA_W = ((OFFSET_BITS + REMAIN_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // byte_offset[OFFSET_BITS], remaining_length[16], zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // track_index[17], sector_id[8], byte_in_sector[10], chunk_length[11], beyond_end[1], pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_SECTORS + 1);
  localparam int IW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
  localparam int QW = OFFSET_BITS - 7;
  localparam int CW = (OFFSET_BITS > AREA_W) ? OFFSET_BITS : AREA_W;

  // Configuration registers
  logic [SPT_W-1:0]    sectors_per_track;
  logic [SLOG_W-1:0]   sector_size_log2;
  logic [SKEW_W-1:0]   skew_step;
  logic [SECTOR_W-1:0] first_sector_id;
  logic [AREA_W-1:0]   area_bytes;
  logic                rebuild;

  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_track <= RST_SECTORS;
      sector_size_log2  <= RST_SIZE_LOG;
      skew_step         <= RST_SKEW;
      first_sector_id   <= RST_FIRST_ID;
      area_bytes        <= RST_AREA;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SECTORS:  sectors_per_track <= cfg_wdata[SPT_W-1:0];
        REG_SIZE_LOG: sector_size_log2  <= cfg_wdata[SLOG_W-1:0];
        REG_SKEW:     skew_step         <= cfg_wdata[SKEW_W-1:0];
        REG_FIRST_ID: first_sector_id   <= cfg_wdata[SECTOR_W-1:0];
        REG_AREA:     area_bytes        <= cfg_wdata[AREA_W-1:0];
        default: ;
      endcase
    end
  end

  assign rebuild = cfg_we && (cfg_addr == REG_SECTORS || cfg_addr == REG_SKEW);

  // Clamped geometry
  logic [NW-1:0]     n_eff;
  logic [SLOG_W-1:0] lg_eff;

  always_comb begin
    if (sectors_per_track == '0) n_eff = NW'(1);
    else if (32'(sectors_per_track) > MAX_SECTORS) n_eff = NW'(MAX_SECTORS);
    else n_eff = NW'(sectors_per_track);
  end

  always_comb begin
    if (sector_size_log2 < SIZE_LOG_MIN) lg_eff = SIZE_LOG_MIN;
    else if (sector_size_log2 > SIZE_LOG_MAX) lg_eff = SIZE_LOG_MAX;
    else lg_eff = sector_size_log2;
  end

  // Front stage: end check, split into sector number and byte in sector, chunk
  logic [OFFSET_BITS-1:0] offset;
  logic [REMAIN_W-1:0]    remaining;
  logic [CHUNK_W-1:0]     sec_size, room, chunk;
  logic [INSEC_W-1:0]     insec;
  logic                   beyond;
  doss_side_t             side;

  assign offset    = s_tdata[OFFSET_BITS-1:0];
  assign remaining = s_tdata[OFFSET_BITS+REMAIN_W-1:OFFSET_BITS];
  assign sec_size  = CHUNK_W'(1) << lg_eff;
  assign insec     = offset[INSEC_W-1:0] & INSEC_W'(sec_size - CHUNK_W'(1));
  assign room      = sec_size - CHUNK_W'(insec);
  assign chunk     = (REMAIN_W'(room) > remaining) ? CHUNK_W'(remaining) : room;
  assign beyond    = CW'(offset) >= CW'(area_bytes);

  always_comb begin
    side                = '0;
    side.beyond_end     = beyond;
    if (!beyond) begin
      side.byte_in_sector = insec;
      side.chunk_length   = chunk;
    end
  end

  logic          f_vld, f_rdy;
  logic [QW-1:0] f_dividend;
  doss_side_t    f_side;
  logic          div_in_rdy;
  logic          busy;

  assign f_rdy    = !f_vld || div_in_rdy;
  assign s_tready = f_rdy && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (f_rdy) begin
      f_vld <= s_tvalid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy) begin
      f_dividend <= QW'(offset >> lg_eff);
      f_side     <= side;
    end
  end

  // Track and logical sector
  logic               div_vld;
  logic [TRACK_W-1:0] div_quot;
  logic [NW-1:0]      div_rem;
  doss_side_t         div_side;
  logic               t_vld, t_rdy;

  doss_div #(
    .OFFSET_BITS (OFFSET_BITS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (f_vld),
    .in_ready    (div_in_rdy),
    .in_dividend (f_dividend),
    .in_side     (f_side),
    .n_eff       (n_eff),
    .out_valid   (div_vld),
    .out_ready   (t_rdy),
    .out_quot    (div_quot),
    .out_rem     (div_rem),
    .out_side    (div_side)
  );

  // Table stage: skew lookup with registered read
  logic [IW-1:0]      skew_entry;
  logic [TRACK_W-1:0] t_track;
  doss_side_t         t_side;
  logic               o_vld, o_rdy;

  doss_table #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .rebuild   (rebuild),
    .n_eff     (n_eff),
    .skew_step (skew_step),
    .busy      (busy),
    .rd_en     (t_rdy),
    .rd_addr   (IW'(div_rem)),
    .rd_data   (skew_entry)
  );

  assign t_rdy = !t_vld || o_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else if (t_rdy) begin
      t_vld <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (t_rdy) begin
      t_track <= div_quot;
      t_side  <= div_side;
    end
  end

  // Output register
  logic [SECTOR_W-1:0]  sector;
  logic [TRACK_W-1:0]   track;
  logic [M_TDATA_W-1:0] out_data;

  assign o_rdy  = !o_vld || m_tready;
  assign sector = t_side.beyond_end ? '0 : first_sector_id + SECTOR_W'(skew_entry);
  assign track  = t_side.beyond_end ? '0 : t_track;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (o_rdy) begin
      o_vld <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      out_data <= {1'b0, t_side.beyond_end, t_side.chunk_length,
                   t_side.byte_in_sector, sector, track};
    end
  end

  assign m_tvalid = o_vld;
  assign m_tdata  = out_data;

endmodule

### sv/doss_checker.sv
// Port-level checks for the translator, attached to the top level by bind.
// Uses doss_pkg for field widths and register codes.
module doss_checker import doss_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_TDATA_W-1:0]  m_tdata,
  input logic                  cfg_we,
  input logic [CFG_ADDR_W-1:0] cfg_addr
);

  logic                beyond;
  logic [INSEC_W-1:0]  insec;
  logic [CHUNK_W-1:0]  chunk;
  logic [CHUNK_W:0]    span;

  // Field positions follow the m_tdata packing
  assign insec  = m_tdata[34:25];
  assign chunk  = m_tdata[45:35];
  assign beyond = m_tdata[46];
  assign span   = (CHUNK_W+1)'(insec) + (CHUNK_W+1)'(chunk);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Past-end results carry no position
  a_beyond_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && beyond |-> m_tdata[45:0] == '0)
    else $error("past-end result has nonzero fields");

  // A chunk never runs past the end of the largest sector
  a_chunk_span: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !beyond |-> span <= (CHUNK_W+1)'(1024))
    else $error("chunk runs past sector end");

  // A geometry change blocks input while the table is rebuilt
  a_rebuild_block: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_addr == REG_SECTORS || cfg_addr == REG_SKEW) |=> !s_tready)
    else $error("input taken during table rebuild");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind disk_offset_to_skewed_sector doss_checker u_doss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .cfg_we   (cfg_we),
  .cfg_addr (cfg_addr)
);

### tb/tb_disk_offset_to_skewed_sector.sv
// Self-checking testbench for disk_offset_to_skewed_sector: directed table, then random phases.
// Predicts each result from its own copy of the geometry registers and skew map unless the step fixes it.
// Depends on doss_pkg and the disk_offset_to_skewed_sector top level.
module tb_disk_offset_to_skewed_sector;
  import doss_pkg::*;

  localparam int OFF_W        = 24;
  localparam int SKEW_DEPTH   = 64;
  localparam int S_DATA_W     = ((OFF_W + REMAIN_W + 7) / 8) * 8;
  localparam int PHASES       = 10;
  localparam int PHASE_BEATS  = 60;
  localparam int HOLD_PHASE   = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 600000;

  // Indexes past the register file; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_5 = CFG_ADDR_W'(5);
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_6 = CFG_ADDR_W'(6);
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_7 = CFG_ADDR_W'(7);

  // Result beat, lowest field last
  typedef struct packed {
    logic                pad;
    logic                beyond_end;
    logic [CHUNK_W-1:0]  chunk_length;
    logic [INSEC_W-1:0]  byte_in_sector;
    logic [SECTOR_W-1:0] sector_id;
    logic [TRACK_W-1:0]  track_index;
  } sector_loc_t;

  typedef enum logic {STEP_BEAT, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    logic [OFF_W-1:0]      offset;
    logic [REMAIN_W-1:0]   length;
    bit                    fixed;
    sector_loc_t           want;
  } dir_step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow geometry registers and skew map
  int unsigned          sectors_cfg, size_log_cfg, skew_cfg, first_id_cfg, area_cfg;
  logic [SKEW_W-1:0]    skew_map [SKEW_DEPTH];

  sector_loc_t pending_locs [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  disk_offset_to_skewed_sector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_disk_offset_to_skewed_sector: done, errors");
      $finish;
    end
  end

  // Out-of-range register values clamp
  function automatic int unsigned eff_sectors();
    if (sectors_cfg == 0) return 1;
    if (sectors_cfg > SKEW_DEPTH) return SKEW_DEPTH;
    return sectors_cfg;
  endfunction

  function automatic int unsigned eff_size_log();
    if (size_log_cfg < SIZE_LOG_MIN) return SIZE_LOG_MIN;
    if (size_log_cfg > SIZE_LOG_MAX) return SIZE_LOG_MAX;
    return size_log_cfg;
  endfunction

  // Step by the skew, slide forward past slots already used; identity when the skew is zero
  function automatic void rebuild_skew_map();
    bit          taken [SKEW_DEPTH];
    int unsigned n, pos, i;
    n = eff_sectors();
    pos = 0;
    for (i = 0; i < SKEW_DEPTH; i++) begin
      skew_map[i] = '0;
      taken[i] = 1'b0;
    end
    for (i = 0; i < n; i++) begin
      if (skew_cfg == 0) begin
        skew_map[i] = SKEW_W'(i);
      end else begin
        while (taken[pos]) pos = (pos + 1) % n;
        skew_map[i] = SKEW_W'(pos);
        taken[pos] = 1'b1;
        pos = (pos + skew_cfg) % n;
      end
    end
  endfunction

  // Expected location of one request under the current geometry
  function automatic sector_loc_t locate_sector(logic [OFF_W-1:0] off, logic [REMAIN_W-1:0] len);
    int unsigned lg, bytes_per_trk, rest, lsec, insec, chunk;
    sector_loc_t r;
    r = '0;
    if (off >= area_cfg) begin
      r.beyond_end = 1'b1;
      return r;
    end
    lg = eff_size_log();
    bytes_per_trk = eff_sectors() << lg;
    rest = off % bytes_per_trk;
    lsec = rest >> lg;
    insec = rest & ((1 << lg) - 1);
    chunk = (1 << lg) - insec;
    if (len < chunk) chunk = len;
    r.track_index    = TRACK_W'(off / bytes_per_trk);
    r.sector_id      = SECTOR_W'(first_id_cfg + skew_map[lsec % SKEW_DEPTH]);
    r.byte_in_sector = INSEC_W'(insec);
    r.chunk_length   = CHUNK_W'(chunk);
    return r;
  endfunction

  function automatic sector_loc_t loc(int unsigned track, int unsigned sec, int unsigned insec,
                                      int unsigned chunk, bit beyond);
    sector_loc_t r;
    r = '0;
    r.track_index    = TRACK_W'(track);
    r.sector_id      = SECTOR_W'(sec);
    r.byte_in_sector = INSEC_W'(insec);
    r.chunk_length   = CHUNK_W'(chunk);
    r.beyond_end     = beyond;
    return r;
  endfunction

  function automatic dir_step_t beat(logic [OFF_W-1:0] off, logic [REMAIN_W-1:0] len);
    dir_step_t s;
    s = '{kind: STEP_BEAT, addr: '0, data: '0, offset: off, length: len, fixed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic dir_step_t beat_at(logic [OFF_W-1:0] off, logic [REMAIN_W-1:0] len,
                                        sector_loc_t want);
    dir_step_t s;
    s = '{kind: STEP_BEAT, addr: '0, data: '0, offset: off, length: len, fixed: 1'b1,
          want: want};
    return s;
  endfunction

  function automatic dir_step_t reg_write(logic [CFG_ADDR_W-1:0] addr,
                                          logic [CFG_DATA_W-1:0] data);
    dir_step_t s;
    s = '{kind: STEP_WRITE, addr: addr, data: data, offset: '0, length: '0, fixed: 1'b0,
          want: '0};
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // Lower valid and wait out every outstanding result
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_locs.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_SECTORS: begin
        sectors_cfg = data[SPT_W-1:0];
        rebuild_skew_map();
      end
      REG_SIZE_LOG: size_log_cfg = data[SLOG_W-1:0];
      REG_SKEW: begin
        skew_cfg = data[SKEW_W-1:0];
        rebuild_skew_map();
      end
      REG_FIRST_ID: first_id_cfg = data[SECTOR_W-1:0];
      REG_AREA:     area_cfg = data[AREA_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_geometry(logic [CFG_DATA_W-1:0] spt, logic [CFG_DATA_W-1:0] slog,
                               logic [CFG_DATA_W-1:0] skew, logic [CFG_DATA_W-1:0] first,
                               logic [CFG_DATA_W-1:0] area);
    write_reg(REG_SECTORS, spt);
    write_reg(REG_SIZE_LOG, slog);
    write_reg(REG_SKEW, skew);
    write_reg(REG_FIRST_ID, first);
    write_reg(REG_AREA, area);
  endtask

  // One request beat; valid stays up after acceptance for back-to-back beats
  task automatic send_item(logic [OFF_W-1:0] off, logic [REMAIN_W-1:0] len, sector_loc_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({len, off});
    do @(posedge clk); while (!s_tready);
    pending_locs = {pending_locs, want};
  endtask

  // Mostly inside the area, some at its end, some in the first 4096 bytes, some anywhere
  function automatic logic [OFF_W-1:0] pick_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (area_cfg == 0 || r < 10) return OFF_W'($urandom);
    if (r < 20) return OFF_W'(area_cfg - 1 + $urandom_range(0, 2));
    if (r < 30) return OFF_W'($urandom_range(0, 4095));
    return OFF_W'($urandom_range(0, area_cfg - 1));
  endfunction

  function automatic logic [REMAIN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return '1;
    if (r < 50) return REMAIN_W'($urandom_range(1, 1100));
    return REMAIN_W'($urandom);
  endfunction

  // Result side: check accepted beats, then pick next ready
  always @(posedge clk) begin : result_side
    sector_loc_t got, want;
    if (m_tvalid && m_tready) begin
      got = sector_loc_t'(m_tdata);
      if (pending_locs.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending, expected none got %h", $time, m_tdata);
      end else begin
        want = pending_locs.pop_front();
        check_field("track_index", want.track_index, got.track_index);
        check_field("sector_id", want.sector_id, got.sector_id);
        check_field("byte_in_sector", want.byte_in_sector, got.byte_in_sector);
        check_field("chunk_length", want.chunk_length, got.chunk_length);
        check_field("beyond_end", want.beyond_end, got.beyond_end);
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    dir_step_t   steps [$];
    dir_step_t   st;
    sector_loc_t want;
    logic [OFF_W-1:0]    off;
    logic [REMAIN_W-1:0] len;
    int unsigned phase;

    sectors_cfg  = RST_SECTORS;
    size_log_cfg = RST_SIZE_LOG;
    skew_cfg     = RST_SKEW;
    first_id_cfg = RST_FIRST_ID;
    area_cfg     = RST_AREA;
    rebuild_skew_map();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: empty area, so every request is past the end
    steps = {steps, beat_at(24'h000000, 16'h0001, loc(0, 0, 0, 0, 1))};
    steps = {steps, beat_at(24'hFFFFFF, 16'hFFFF, loc(0, 0, 0, 0, 1))};
    steps = {steps, beat_at(24'h000000, 16'h0000, loc(0, 0, 0, 0, 1))};
    // Unmapped indexes would alias size, skew and first id if decoded short
    steps = {steps, reg_write(REG_UNMAPPED_5, 24'd10)};
    steps = {steps, reg_write(REG_UNMAPPED_6, 24'd3)};
    steps = {steps, reg_write(REG_UNMAPPED_7, 24'h77)};
    steps = {steps, reg_write(REG_AREA, 24'hFFFFFF)};
    // 26 sectors of 128, identity skew, ids from 1
    steps = {steps, beat_at(24'd0, 16'd1, loc(0, 1, 0, 1, 0))};
    steps = {steps, beat_at(24'd0, 16'hFFFF, loc(0, 1, 0, 128, 0))};
    steps = {steps, beat_at(24'd127, 16'hFFFF, loc(0, 1, 127, 1, 0))};
    steps = {steps, beat_at(24'd128, 16'd0, loc(0, 2, 0, 0, 0))};
    steps = {steps, beat_at(24'd3327, 16'd5, loc(0, 26, 127, 1, 0))};
    steps = {steps, beat_at(24'd3328, 16'd300, loc(1, 1, 0, 128, 0))};
    steps = {steps, beat(24'hFFFFFF, 16'hFFFF)};
    // Largest geometry, widest skew, id wrap past 255; spare data bits set
    steps = {steps, reg_write(REG_SECTORS, 24'hABCD40)};
    steps = {steps, reg_write(REG_SIZE_LOG, 24'd10)};
    steps = {steps, reg_write(REG_SKEW, 24'd63)};
    steps = {steps, reg_write(REG_FIRST_ID, 24'd255)};
    steps = {steps, beat(24'd0, 16'hFFFF)};
    steps = {steps, beat(24'd1024, 16'd1000)};
    steps = {steps, beat(24'd65535, 16'd2)};
    steps = {steps, beat(24'hFFFFFF, 16'hFFFF)};
    // Zero sector count and too-small size clamp up
    steps = {steps, reg_write(REG_SECTORS, 24'd0)};
    steps = {steps, reg_write(REG_SIZE_LOG, 24'd0)};
    steps = {steps, reg_write(REG_SKEW, 24'd1)};
    steps = {steps, reg_write(REG_FIRST_ID, 24'd128)};
    steps = {steps, beat(24'd0, 16'd200)};
    steps = {steps, beat(24'hFFFFFF, 16'd1)};
    steps = {steps, beat(24'h123456, 16'h8000)};
    // Oversized count and size clamp down
    steps = {steps, reg_write(REG_SECTORS, 24'd127)};
    steps = {steps, reg_write(REG_SIZE_LOG, 24'd15)};
    steps = {steps, reg_write(REG_SKEW, 24'd2)};
    steps = {steps, beat(24'd70000, 16'd513)};
    steps = {steps, beat(24'hFFFFFF, 16'hFFFF)};
    // End of a small area
    steps = {steps, reg_write(REG_AREA, 24'd1000)};
    steps = {steps, beat(24'd999, 16'd1)};
    steps = {steps, beat_at(24'd1000, 16'd1, loc(0, 0, 0, 0, 1))};
    steps = {steps, beat_at(24'd1001, 16'hFFFF, loc(0, 0, 0, 0, 1))};

    send_idle_pct  = 13;
    recv_stall_pct = 13;
    foreach (steps[i]) begin
      st = steps[i];
      if (st.kind == STEP_WRITE) begin
        write_reg(st.addr, st.data);
      end else begin
        want = st.fixed ? st.want : locate_sector(st.offset, st.length);
        send_item(st.offset, st.length, want);
      end
    end

    // Random phases: fixed extremes first, then random geometry
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_geometry(24'd1, 24'd7, 24'd0, 24'd0, 24'hFFFFFF);
        1: load_geometry(24'd64, 24'd10, 24'd63, 24'd255, 24'hFFFFFF);
        2: load_geometry(24'd0, 24'd15, 24'd1, 24'd200, 24'($urandom));
        3: load_geometry(24'd127, 24'd0, 24'd5, 24'd1, 24'd5000);
        4: load_geometry(24'd26, 24'd8, 24'd3, 24'd0, 24'd0);
        default: load_geometry(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                               24'($urandom));
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      // Long result-side hold while requests keep coming
      if (phase == HOLD_PHASE) hold_left = HOLD_CYCLES;
      repeat (PHASE_BEATS) begin
        off = pick_offset();
        len = pick_length();
        send_item(off, len, locate_sector(off, len));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_locs.size() == 0) begin
      $display("tb_disk_offset_to_skewed_sector: done, clean");
    end else begin
      $display("tb_disk_offset_to_skewed_sector: done, errors");
    end
    $finish;
  end

endmodule
